### rtl/pcx_pkg.sv
// shared types and constants for the pcx run-length palette decoder
// no dependencies; imported by the front end, queue, back end and top level
package pcx_pkg;

  localparam int COLOR_W = 24;
  localparam int COORD_W = 16;
  localparam int DIM_W   = 17;
  localparam int COUNT_W = 6;
  localparam int PALETTE_ENTRIES = 256;

  // top two bits of a run header byte
  localparam logic [1:0] RUN_MARK = 2'b11;

  // word kinds on the input channel
  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_IMAGE   = 1'b1;

  // configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // pixel slot of a full run that is dropped when the data ends there
  localparam logic [COUNT_W-1:0] EOD_CUTOFF = 6'd62;

  localparam logic [DIM_W-1:0] DIM_MIN = 17'd1;
  localparam logic [DIM_W-1:0] DIM_MAX = 17'd65536;

  // decoded command from front to back
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               eod;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  // one result word
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               last;
    logic               done;
    logic               err;
  } res_t;

endpackage

### rtl/pcx_front.sv
// front end: accepts input words, holds the palette memory, tracks run headers
// depends on pcx_pkg; feeds decoded commands into the command queue
module pcx_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          kind,
  input  logic [7:0]    palette_index,
  input  logic [23:0]   palette_color,
  input  logic [7:0]    data_byte,
  input  logic          end_of_data,
  output pcx_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready
);
  import pcx_pkg::*;

  logic [COLOR_W-1:0] palette_mem [PALETTE_ENTRIES];
  logic [COLOR_W-1:0] rd_data_r;

  logic               run_pending_r, run_pending_nxt;
  logic [COUNT_W-1:0] pend_count_r, pend_count_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  logic [COUNT_W-1:0] s1_count_r;
  logic               s1_eod_r;

  logic               accept;
  logic               img_acc;
  logic               is_header;
  logic [COUNT_W-1:0] new_count;
  logic               gives_cmd;

  // handshake and byte classification
  assign in_ready  = !s1_valid_r || cmd_ready;
  assign accept    = in_valid && in_ready;
  assign img_acc   = accept && (kind == KIND_IMAGE);
  assign is_header = !run_pending_r && (data_byte[7:6] == RUN_MARK);
  assign new_count = is_header ? '0 : (run_pending_r ? pend_count_r : COUNT_W'(1));
  // a header word only matters to the back end when the data ends on it
  assign gives_cmd = (new_count != '0) || end_of_data;

  always_comb begin
    run_pending_nxt = run_pending_r;
    pend_count_nxt  = pend_count_r;
    s1_valid_nxt    = s1_valid_r && !cmd_ready;
    if (img_acc) begin
      run_pending_nxt = is_header;
      pend_count_nxt  = is_header ? data_byte[COUNT_W-1:0] : '0;
      s1_valid_nxt    = gives_cmd;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_pending_r <= 1'b0;
      pend_count_r  <= '0;
      s1_valid_r    <= 1'b0;
    end else begin
      run_pending_r <= run_pending_nxt;
      pend_count_r  <= pend_count_nxt;
      s1_valid_r    <= s1_valid_nxt;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (img_acc) begin
      s1_count_r <= new_count;
      s1_eod_r   <= end_of_data;
    end
  end

  // palette memory, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (accept && (kind == KIND_PALETTE)) begin
      palette_mem[palette_index] <= palette_color;
    end
    if (img_acc) begin
      rd_data_r <= palette_mem[data_byte];
    end
  end

  assign cmd       = '{count: s1_count_r, eod: s1_eod_r, color: rd_data_r};
  assign cmd_valid = s1_valid_r;

endmodule

### rtl/pcx_cmd_fifo.sv
// small register queue of decoded commands between front and back
// depends on pcx_pkg for the command type
module pcx_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pcx_pkg::cmd_t push_data,
  input  logic          push_valid,
  output logic          push_ready,
  output pcx_pkg::cmd_t pop_data,
  output logic          pop_valid,
  input  logic          pop_ready
);
  import pcx_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign push_ready = (fill_r != CNT_W'(DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = entries_r[rd_ptr_r];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/pcx_back.sv
// back end: expands commands into pixels, tracks column and row, flags errors
// depends on pcx_pkg; drives the registered result word
module pcx_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pcx_pkg::cmd_t             cmd,
  input  logic                      cmd_valid,
  output logic                      cmd_pop,
  input  logic [pcx_pkg::DIM_W-1:0] img_width,
  input  logic [pcx_pkg::DIM_W-1:0] img_height,
  output pcx_pkg::res_t             res,
  output logic                      res_valid,
  input  logic                      res_ready
);
  import pcx_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_ERR
  } state_t;

  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [COUNT_W-1:0] emitted_r, emitted_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic               eod_r, eod_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic               complete_r, complete_nxt;
  logic               res_valid_r, res_valid_nxt;
  res_t               res_r, res_nxt;

  logic               slot_free;
  logic [DIM_W-1:0]   col_inc, row_inc;
  logic               row_end, final_px, cut;

  // position compares for the pixel at hand
  assign slot_free = !res_valid_r || res_ready;
  assign col_inc   = {1'b0, col_r} + DIM_W'(1);
  assign row_inc   = {1'b0, row_r} + DIM_W'(1);
  assign row_end   = (col_inc >= img_width);
  assign final_px  = row_end && (row_inc >= img_height);
  assign cut       = eod_r && (emitted_r == EOD_CUTOFF) && !final_px;

  assign cmd_pop = (state_r == ST_IDLE) && cmd_valid;

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    emitted_nxt   = emitted_r;
    color_nxt     = color_r;
    eod_nxt       = eod_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    complete_nxt  = complete_r;
    res_valid_nxt = res_valid_r && !res_ready;
    res_nxt       = res_r;
    unique case (state_r)
      ST_IDLE: begin
        // commands after completion are dropped
        if (cmd_valid && !complete_r) begin
          rem_nxt     = cmd.count;
          emitted_nxt = '0;
          color_nxt   = cmd.color;
          eod_nxt     = cmd.eod;
          if (cmd.count != '0) begin
            state_nxt = ST_RUN;
          end else if (cmd.eod) begin
            state_nxt = ST_ERR;
          end
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          if (cut) begin
            state_nxt = ST_ERR;
          end else begin
            res_valid_nxt = 1'b1;
            res_nxt = '{color:  color_r,
                        column: col_r,
                        row:    row_r,
                        last:   final_px || (!eod_r && (row_end || rem_r == COUNT_W'(1))),
                        done:   final_px,
                        err:    1'b0};
            rem_nxt     = rem_r - COUNT_W'(1);
            emitted_nxt = emitted_r + COUNT_W'(1);
            if (row_end) begin
              col_nxt = '0;
              row_nxt = final_px ? '0 : row_r + COORD_W'(1);
            end else begin
              col_nxt = col_r + COORD_W'(1);
            end
            if (final_px) begin
              complete_nxt = 1'b1;
              state_nxt    = ST_IDLE;
            end else if (row_end || rem_r == COUNT_W'(1)) begin
              state_nxt = eod_r ? ST_ERR : ST_IDLE;
            end
          end
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          res_valid_nxt = 1'b1;
          res_nxt = '{color: '0, column: '0, row: '0,
                      last: 1'b1, done: 1'b0, err: 1'b1};
          complete_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      complete_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      complete_r  <= complete_nxt;
      res_valid_r <= res_valid_nxt;
    end
    rem_r     <= rem_nxt;
    emitted_r <= emitted_nxt;
    color_r   <= color_nxt;
    eod_r     <= eod_nxt;
    res_r     <= res_nxt;
  end

  assign res       = res_r;
  assign res_valid = res_valid_r;

endmodule

### rtl/pcx_rle_palette_decoder.sv
// top level of the pcx run-length palette decoder
// depends on pcx_pkg, pcx_front, pcx_cmd_fifo and pcx_back
//
// Decodes 8-bit palette PCX image data. Palette words (in_tuser 0) write one
// 24-bit entry and give no result; image words (in_tuser 1) carry one
// encoded byte each. The front end takes one word per cycle while the
// command queue has room; the palette memory read is registered there. The
// back end sets the rate: it takes a command only in its idle state, then
// emits that command's pixels in turn while the output is not stalled, plus
// an error word when the data ends early. Width and height are written
// through the cfg port; the user must write them only while the block is
// idle, the block itself does not enforce it. Zero is taken as 1 and values
// above 65536 as 65536. After the last pixel or an error word, image words
// are ignored until reset.
module pcx_rle_palette_decoder #(
  parameter int CMD_QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // palette_index[7:0], palette_color[31:8], data_byte[39:32]
  input  logic        in_tuser,   // kind
  input  logic        in_tlast,   // end_of_data
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // red[7:0], green[15:8], blue[23:16], column[39:24], row[55:40]
  output logic [1:0]  out_tuser,  // image_done[0], data_error[1]
  output logic        out_tlast,  // last_of_run
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);
  import pcx_pkg::*;

  logic [DIM_W-1:0] width_r, height_r;
  logic [DIM_W-1:0] cfg_dim;

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready;
  logic back_valid, back_pop;
  res_t res;

  // configuration registers, stored already clamped
  assign cfg_ready = 1'b1;
  assign cfg_dim   = (cfg_data == '0) ? DIM_MIN :
                     ((cfg_data > DIM_MAX) ? DIM_MAX : cfg_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_MIN;
      height_r <= DIM_MIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_dim;
        CFG_HEIGHT: height_r <= cfg_dim;
        default:    width_r  <= width_r;
      endcase
    end
  end

  pcx_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .kind          (in_tuser),
    .palette_index (in_tdata[7:0]),
    .palette_color (in_tdata[31:8]),
    .data_byte     (in_tdata[39:32]),
    .end_of_data   (in_tlast),
    .cmd           (front_cmd),
    .cmd_valid     (front_valid),
    .cmd_ready     (front_ready)
  );

  pcx_cmd_fifo #(
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (front_cmd),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_data   (back_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_pop)
  );

  pcx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (back_cmd),
    .cmd_valid  (back_valid),
    .cmd_pop    (back_pop),
    .img_width  (width_r),
    .img_height (height_r),
    .res        (res),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready)
  );

  // result word packing
  assign out_tdata = {res.row, res.column, res.color[7:0], res.color[15:8], res.color[23:16]};
  assign out_tuser = {res.err, res.done};
  assign out_tlast = res.last;

endmodule

### rtl/pcx_chk.sv
// port-level checks for the pcx run-length palette decoder
// depends only on the top level's ports; bound to the top level below
module pcx_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // the error word carries no pixel and closes its input
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == 56'd0 && out_tlast && !out_tuser[0])
    else $error("malformed error word");

  // the final pixel always closes its input
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("final pixel not marked last");

endmodule

bind pcx_rle_palette_decoder pcx_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
